// ===== rtl/lqfl_pkg.sv =====
package lqfl_pkg;

  localparam int CMD_W    = 1;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
  localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic ready;
    logic take;
    logic push_link;
    logic pop_link;
    logic load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== rtl/lqfl_in_if.sv =====
interface lqfl_in_if;
  logic                             valid;
  logic                             ready;
  logic [lqfl_pkg::CMD_W-1:0]       cmd;
  logic [lqfl_pkg::HANDLE_W-1:0]    push_data;

  modport source (output valid, output cmd, output push_data, input ready);
  modport sink   (input valid, input cmd, input push_data, output ready);
endinterface

// ===== rtl/lqfl_out_if.sv =====
interface lqfl_out_if;
  logic                             valid;
  logic                             ready;
  logic [lqfl_pkg::STATUS_W-1:0]    status;
  logic [lqfl_pkg::HANDLE_W-1:0]    pop_data;
  logic [lqfl_pkg::COUNT_W-1:0]     item_count;

  modport source (output valid, output status, output pop_data, output item_count,
                  input ready);
  modport sink   (input valid, input status, input pop_data, input item_count,
                  output ready);
endinterface

// ===== rtl/lqfl_ctrl.sv =====
module lqfl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_pop,
  input  lqfl_pkg::ctl_sts_t sts,
  output lqfl_pkg::ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_PUSH_LINK = 5'b00010,
    S_POP_LINK  = 5'b00100,
    S_POP_DATA  = 5'b01000,
    S_RESULT    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_pop) begin
            state_next = S_POP_LINK;
          end else if (sts.full) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_PUSH_LINK;
          end
        end
      end
      S_PUSH_LINK: begin
        cmd.push_link = 1'b1;
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_POP_LINK: begin
        cmd.pop_link = 1'b1;
        state_next   = sts.empty ? S_RESULT : S_POP_DATA;
      end
      S_POP_DATA: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lqfl_dp.sv =====
module lqfl_dp #(
  parameter int NODES      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lqfl_pkg::ctl_cmd_t                cmd,
  output lqfl_pkg::ctl_sts_t                sts,
  input  logic [lqfl_pkg::CMD_W-1:0]        req_cmd,
  input  logic [lqfl_pkg::HANDLE_W-1:0]     req_push_data,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [lqfl_pkg::STATUS_W-1:0]     rsp_status,
  output logic [lqfl_pkg::HANDLE_W-1:0]     rsp_pop_data,
  output logic [lqfl_pkg::COUNT_W-1:0]      rsp_item_count
);

  localparam int IW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW  = $clog2(NODES + 1);
  localparam int CW  = IW;
  localparam int CXW = (CW > lqfl_pkg::COUNT_W) ? CW : lqfl_pkg::COUNT_W;
  localparam int XW  = (DATA_WIDTH > lqfl_pkg::HANDLE_W) ? DATA_WIDTH : lqfl_pkg::HANDLE_W;
  localparam logic [LW-1:0] LINK_END = LW'(NODES);
  localparam logic [LW-1:0] LAST_IDX = LW'(NODES - 1);

  logic [DATA_WIDTH-1:0] data_mem [NODES];
  logic [LW-1:0]         link_mem [NODES];

  logic [IW-1:0]         head;
  logic [IW-1:0]         tail;
  logic [LW-1:0]         free_head;
  logic [CW-1:0]         count;
  logic [LW-1:0]         fill;

  logic [IW-1:0]         raddr;
  logic [LW-1:0]         link_rd;
  logic                  link_fresh;
  logic [DATA_WIDTH-1:0] data_rd;
  lqfl_pkg::status_t     res_status;
  logic                  res_pop;

  logic                  link_re;
  logic [IW-1:0]         link_raddr;
  logic                  link_we;
  logic [IW-1:0]         link_waddr;
  logic [LW-1:0]         link_wdata;
  logic [LW-1:0]         link_init;
  logic [LW-1:0]         link_val;
  logic [IW-1:0]         free_idx;
  logic [IW-1:0]         next_idx;
  logic                  take_push;
  logic                  full;
  logic [XW-1:0]         push_ext;
  logic [XW-1:0]         pop_ext;
  logic [CXW-1:0]        count_ext;

  assign full      = (free_head == LINK_END);
  assign free_idx  = free_head[IW-1:0];
  assign take_push = cmd.take && (req_cmd == lqfl_pkg::CMD_PUSH) && !full;
  assign push_ext  = XW'(req_push_data);

  // nodes past the fill mark read as their power-up chain, not from link_mem
  assign link_init = (raddr == '0 || LW'(raddr) == LAST_IDX) ? LINK_END : LW'(raddr) + LW'(1);
  assign link_val  = link_fresh ? link_init : link_rd;
  assign next_idx  = link_val[IW-1:0];

  always_comb begin
    link_re    = 1'b0;
    link_raddr = head;
    link_we    = 1'b0;
    link_waddr = free_idx;
    link_wdata = LINK_END;
    if (cmd.take) begin
      link_re = (req_cmd == lqfl_pkg::CMD_POP) || take_push;
      if (req_cmd == lqfl_pkg::CMD_PUSH) begin
        link_raddr = free_idx;
      end
      link_we = take_push;
    end else if (cmd.push_link) begin
      link_we    = 1'b1;
      link_waddr = tail;
      link_wdata = LW'(raddr);
    end else if (cmd.pop_link && link_val != LINK_END) begin
      link_we    = 1'b1;
      link_waddr = head;
      link_wdata = free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (link_re) begin
      link_rd    <= link_mem[link_raddr];
      link_fresh <= (LW'(link_raddr) >= fill);
      raddr      <= link_raddr;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (take_push) begin
      data_mem[free_idx] <= push_ext[DATA_WIDTH-1:0];
    end
    if (cmd.pop_link && link_val != LINK_END) begin
      data_rd <= data_mem[next_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_pop    <= (req_cmd == lqfl_pkg::CMD_POP);
      res_status <= (req_cmd == lqfl_pkg::CMD_PUSH && full) ? lqfl_pkg::ST_FULL
                                                              : lqfl_pkg::ST_DONE;
    end else if (cmd.pop_link && link_val == LINK_END) begin
      res_status <= lqfl_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      free_head <= LW'(1);
      count     <= '0;
      fill      <= '0;
    end else begin
      if (take_push) begin
        count <= count + CW'(1);
        if (LW'(free_idx) >= fill) begin
          fill <= LW'(free_idx) + LW'(1);
        end
      end
      if (cmd.push_link) begin
        tail      <= raddr;
        free_head <= link_val;
      end
      if (cmd.pop_link && link_val != LINK_END) begin
        head      <= next_idx;
        free_head <= LW'(head);
        if (count != '0) begin
          count <= count - CW'(1);
        end
      end
    end
  end

  // result word
  assign pop_ext   = XW'(data_rd);
  assign count_ext = CXW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp_status     <= res_status;
      rsp_pop_data   <= (res_pop && res_status == lqfl_pkg::ST_DONE)
                        ? pop_ext[lqfl_pkg::HANDLE_W-1:0] : '0;
      rsp_item_count <= count_ext[lqfl_pkg::COUNT_W-1:0];
    end
  end

  assign sts.full     = full;
  assign sts.empty    = (link_val == LINK_END);
  assign sts.out_free = !rsp_valid || rsp_ready;

endmodule

// ===== rtl/linked_queue_with_free_list.sv =====
// flow: a push goes from IDLE to PUSH_LINK (to RESULT when full), a pop to POP_LINK, then
//   POP_DATA (RESULT when empty); each request is finished before IDLE takes the next, set by
//   the node memory's registered read (link, then data on a pop); a waiting result lets one
//   more word in, then holds the input until it is taken
// reset: synchronous rst clears pointers, count, fill mark and output valid; node memories
//   get no clearing pass, nodes beyond the fill mark read as the power-up free chain
module linked_queue_with_free_list #(
  parameter int NODES      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  lqfl_in_if.sink           req,
  lqfl_out_if.source        rsp
);

  lqfl_pkg::ctl_cmd_t cmd;
  lqfl_pkg::ctl_sts_t sts;

  assign req.ready = cmd.ready;

  lqfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_pop   (req.cmd == lqfl_pkg::CMD_POP),
    .sts      (sts),
    .cmd      (cmd)
  );

  lqfl_dp #(
    .NODES      (NODES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_cmd        (req.cmd),
    .req_push_data  (req.push_data),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_pop_data   (rsp.pop_data),
    .rsp_item_count (rsp.item_count)
  );

endmodule

// ===== tb/lqfl_queue_checker.sv =====
`timescale 1ns / 1ps

module lqfl_queue_checker (
  input  logic clk,
  input  logic rst,
  lqfl_in_if   req,
  lqfl_out_if  rsp,
  output int   errors,
  output int   pending
);

  localparam int NODES = 16;
  localparam logic [4:0] LINK_END = 5'(NODES);

  typedef struct packed {
    lqfl_pkg::status_t                   status;
    logic [lqfl_pkg::HANDLE_W-1:0]       pop_data;
    logic [lqfl_pkg::COUNT_W-1:0]        item_count;
  } result_word_t;

  logic [lqfl_pkg::HANDLE_W-1:0] node_data [NODES];
  logic [4:0]                    node_link [NODES];
  logic [3:0]                    head_idx;
  logic [3:0]                    tail_idx;
  logic [4:0]                    free_head;
  logic [lqfl_pkg::COUNT_W-1:0]  fill_count;

  result_word_t awaited_results [$];

  task automatic clear_pool();
    for (int i = 0; i < NODES; i++) begin
      node_data[i] = '0;
      node_link[i] = (i + 1 < NODES) ? 5'(i + 1) : LINK_END;
    end
    node_link[0] = LINK_END;
    head_idx   = '0;
    tail_idx   = '0;
    free_head  = 5'd1;
    fill_count = '0;
  endtask

  function automatic result_word_t next_result(input logic [lqfl_pkg::CMD_W-1:0] cmd,
                                               input logic [lqfl_pkg::HANDLE_W-1:0] handle);
    result_word_t r;
    logic [3:0] n;
    logic [3:0] h;
    logic [4:0] nx;
    r.status   = lqfl_pkg::ST_DONE;
    r.pop_data = '0;
    if (cmd == lqfl_pkg::CMD_PUSH) begin
      if (free_head >= LINK_END) begin
        r.status = lqfl_pkg::ST_FULL;
      end else begin
        n = free_head[3:0];
        free_head = node_link[n];
        node_data[n] = handle;
        node_link[n] = LINK_END;
        node_link[tail_idx] = {1'b0, n};
        tail_idx = n;
        fill_count = fill_count + 1'b1;
      end
    end else begin
      h = head_idx;
      nx = node_link[h];
      if (nx >= LINK_END) begin
        r.status = lqfl_pkg::ST_EMPTY;
      end else begin
        r.pop_data = node_data[nx[3:0]];
        head_idx = nx[3:0];
        node_link[h] = free_head;
        free_head = {1'b0, h};
        if (fill_count != 0) fill_count = fill_count - 1'b1;
      end
    end
    r.item_count = fill_count;
    return r;
  endfunction

  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      clear_pool();
      awaited_results.delete();
      errors = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with none awaited: status %0d pop_data %0h item_count %0d",
                 rsp.status, rsp.pop_data, rsp.item_count);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.pop_data !== want.pop_data) begin
            $error("pop_data expected %0h got %0h", want.pop_data, rsp.pop_data);
            errors++;
          end
          if (rsp.item_count !== want.item_count) begin
            $error("item_count expected %0d got %0d", want.item_count, rsp.item_count);
            errors++;
          end
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(next_result(req.cmd, req.push_data));
    end
    pending <= awaited_results.size();
  end

endmodule

// ===== tb/tb_linked_queue_with_free_list.sv =====
`timescale 1ns / 1ps

module tb_linked_queue_with_free_list;

  localparam int RANDOM_WORDS = 1550;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   awaited_count;
  int   cycle_count = 0;
  logic hold_request = 1'b0;

  lqfl_in_if  req_ch ();
  lqfl_out_if rsp_ch ();

  linked_queue_with_free_list dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lqfl_queue_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (fail_count),
    .pending (awaited_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_linked_queue_with_free_list NOT OK");
      $finish;
    end
  end

  task automatic send_word(input logic [lqfl_pkg::CMD_W-1:0] cmd,
                           input logic [lqfl_pkg::HANDLE_W-1:0] handle);
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= cmd;
    req_ch.push_data <= handle;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
  endtask

  function automatic logic [lqfl_pkg::HANDLE_W-1:0] random_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // receiver: ready pattern in modes, one long hold-off on request
  initial begin
    int hold_left;
    int mode_left;
    int ready_pct;
    bit hold_served;
    rsp_ch.ready = 1'b0;
    hold_left   = 0;
    mode_left   = 0;
    ready_pct   = 100;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 90;
            2:       ready_pct = 50;
            default: ready_pct = 25;
          endcase
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  initial begin
    int burst_left;
    int seg_left;
    int push_pct;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.cmd       = lqfl_pkg::CMD_PUSH;
    req_ch.push_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // extremes of the handle, pop on empty
    send_word(lqfl_pkg::CMD_POP, '1);
    send_word(lqfl_pkg::CMD_PUSH, '1);
    send_word(lqfl_pkg::CMD_PUSH, '0);
    send_word(lqfl_pkg::CMD_PUSH, 32'haaaa_aaaa);
    send_word(lqfl_pkg::CMD_PUSH, 32'h5555_5555);
    repeat (4) send_word(lqfl_pkg::CMD_POP, '0);
    send_word(lqfl_pkg::CMD_POP, 32'h1234_5678);
    // fill the pool, then one push too many
    repeat (15) send_word(lqfl_pkg::CMD_PUSH, random_handle());
    send_word(lqfl_pkg::CMD_PUSH, 32'hdead_beef);
    wait_drained();

    burst_left = 0;
    seg_left   = 0;
    push_pct   = 50;
    for (int sent = 0; sent < RANDOM_WORDS; sent++) begin
      if (sent == 300) hold_request <= 1'b1;
      if (sent == 800) wait_drained();
      if (seg_left == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
        seg_left = $urandom_range(20, 120);
      end
      seg_left--;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 20);
        pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
      end
      burst_left--;
      if ($urandom_range(1, 100) <= push_pct)
        send_word(lqfl_pkg::CMD_PUSH, random_handle());
      else
        send_word(lqfl_pkg::CMD_POP, random_handle());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && awaited_count == 0)
      $display("tb_linked_queue_with_free_list OK");
    else
      $display("tb_linked_queue_with_free_list NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lqfl_pkg.sv
rtl/lqfl_in_if.sv
rtl/lqfl_out_if.sv
rtl/lqfl_ctrl.sv
rtl/lqfl_dp.sv
rtl/linked_queue_with_free_list.sv
tb/lqfl_queue_checker.sv
tb/tb_linked_queue_with_free_list.sv
